### design/bfns_pkg.sv
`default_nettype none
package bfns_pkg;

  localparam int MAX_VARIABLES = 1024;
  localparam int WORD_BITS     = 64;
  localparam int WORD_COUNT    = (MAX_VARIABLES + WORD_BITS - 1) / WORD_BITS;

  localparam int IDX_W   = $clog2(MAX_VARIABLES);
  localparam int CNT_W   = $clog2(MAX_VARIABLES + 1);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int POP_W   = $clog2(WORD_BITS + 1);
  localparam int CMD_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK       = 3'd0,
    CMD_UNMARK     = 3'd1,
    CMD_TEST       = 3'd2,
    CMD_FIND_CLEAR = 3'd3,
    CMD_FIND_SET   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] target_index;
  } in_item_t;

  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             all_filled;
    logic             out_of_range;
  } out_item_t;

  // word evaluation result from the scan unit
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
    logic [POP_W-1:0] ones;
  } scan_res_t;

endpackage
`default_nettype wire

### design/bitmap_find_next_set_clear_top.sv
`default_nettype none
// Filled-mark bitmap with mark, unmark, test and next-set / next-clear search.
//
// Input channel (in_valid / in_stall / in_data): one command and index per
// transaction. Result channel (out_valid / out_stall / out_data): one result
// per finished command, in order. Configuration: cfg_wr_en / cfg_wr_data write
// the variable count; the count is saturated to the bitmap size.
//
// The marks live in a 16 x 64 single-port synchronous RAM. A command is taken
// only while the controller is idle; for mark, unmark, test and out-of-range
// indices, its result is registered from the word read at acceptance.
// A search reads one word per cycle from the start word up to the word that
// holds the last valid index. The next command can be taken
// in the cycle after the result is registered. A count write drops any
// command in progress and starts a recount pass over all 16 RAM words,
// during which in_stall is high.
// Reset (rst_n low, synchronous) clears the per-word valid bits, so every
// word reads as zero until first written; the count resets to 1024.
// While out_stall holds a finished result, the next result waits in the
// controller with the RAM word and state frozen.
module bitmap_find_next_set_clear_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bfns_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bfns_pkg::out_item_t             out_data,
  input  wire logic                       cfg_wr_en,
  input  wire logic [bfns_pkg::CNT_W-1:0] cfg_wr_data
);
  import bfns_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_RECOUNT
  } state_t;

  // control state
  state_t             state_r,     state_nxt;
  logic [CNT_W-1:0]   vc_r,        vc_nxt;
  logic [CNT_W-1:0]   count_r,     count_nxt;
  logic [CNT_W-1:0]   acc_r,       acc_nxt;
  logic [WADDR_W-1:0] cur_word_r,  cur_word_nxt;
  logic               first_r,     first_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_COUNT-1:0] wvalid_r, wvalid_nxt;

  // payload
  logic [CMD_W-1:0]   cmd_r,       cmd_nxt;
  logic [IDX_W-1:0]   idx_r,       idx_nxt;
  logic               oor_r,       oor_nxt;
  logic               bit_r,       bit_nxt;
  out_item_t          out_r,       out_nxt;

  // RAM
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     n_m1;
  logic [WADDR_W-1:0]   last_word;
  logic [WORD_BITS-1:0] word_eff;
  logic                 tgt_bit;
  logic                 tgt_mark;
  logic                 is_mark;
  logic                 is_unmark;
  logic                 is_search;
  logic                 finish;
  logic                 can_emit;
  logic                 in_accept;
  scan_res_t            scan;

  assign n_eff     = (vc_r > CNT_W'(MAX_VARIABLES)) ? CNT_W'(MAX_VARIABLES) : vc_r;
  assign n_m1      = n_eff - CNT_W'(1);
  assign last_word = n_m1[IDX_W-1:BIT_W];

  // words never written since reset read as zero
  assign word_eff = wvalid_r[cur_word_r] ? rdata_r : '0;
  assign tgt_bit  = word_eff[idx_r[BIT_W-1:0]];
  assign tgt_mark = first_r ? tgt_bit : bit_r;

  assign is_mark   = (cmd_r == CMD_MARK);
  assign is_unmark = (cmd_r == CMD_UNMARK);
  assign is_search = (cmd_r == CMD_FIND_CLEAR) || (cmd_r == CMD_FIND_SET);

  assign in_stall  = (state_r != ST_IDLE) || cfg_wr_en;
  assign in_accept = in_valid && !in_stall;
  assign can_emit  = !out_valid_r || !out_stall;
  assign finish    = oor_r || !is_search || scan.hit || (cur_word_r == last_word);

  bfns_scan u_scan (
    .word      (word_eff),
    .word_idx  (cur_word_r),
    .lo_bit    (idx_r[BIT_W-1:0]),
    .first     ((state_r == ST_WORK) && first_r),
    .n_eff     (n_eff),
    .want      (cmd_r == CMD_FIND_SET),
    .res       (scan)
  );

  always_comb begin
    state_nxt     = state_r;
    vc_nxt        = vc_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    cur_word_nxt  = cur_word_r;
    first_nxt     = first_r;
    wvalid_nxt    = wvalid_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    oor_nxt       = oor_r;
    bit_nxt       = bit_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_addr       = cur_word_r;
    mem_we        = 1'b0;
    mem_wdata     = word_eff;

    if (cfg_wr_en) begin
      // new count: recount from word 0
      vc_nxt       = cfg_wr_data;
      state_nxt    = ST_RECOUNT;
      cur_word_nxt = '0;
      acc_nxt      = '0;
      rd_en        = 1'b1;
      rd_addr      = '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_nxt      = in_data.command;
            idx_nxt      = in_data.target_index;
            oor_nxt      = CNT_W'(in_data.target_index) >= n_eff;
            cur_word_nxt = in_data.target_index[IDX_W-1:BIT_W];
            first_nxt    = 1'b1;
            rd_en        = 1'b1;
            rd_addr      = in_data.target_index[IDX_W-1:BIT_W];
            state_nxt    = ST_WORK;
          end
        end

        ST_WORK: begin
          if (first_r) begin
            bit_nxt = tgt_bit;
          end
          if (finish) begin
            if (can_emit) begin
              out_valid_nxt         = 1'b1;
              out_nxt.out_of_range  = oor_r;
              out_nxt.bit_value     = !oor_r && tgt_mark;
              out_nxt.found         = !oor_r && is_search && scan.hit;
              out_nxt.found_index   = (!oor_r && is_search && scan.hit) ?
                                      {cur_word_r, scan.pos} : '0;
              out_nxt.all_filled    = (count_r == n_eff);
              if (!oor_r && (is_mark || is_unmark)) begin
                mem_we    = 1'b1;
                mem_wdata = word_eff;
                mem_wdata[idx_r[BIT_W-1:0]] = is_mark;
                wvalid_nxt[cur_word_r] = 1'b1;
                if (is_mark && !tgt_bit) begin
                  count_nxt = count_r + CNT_W'(1);
                end else if (is_unmark && tgt_bit) begin
                  count_nxt = count_r - CNT_W'(1);
                end
                out_nxt.all_filled = (count_nxt == n_eff);
              end
              state_nxt = ST_IDLE;
            end
          end else begin
            // continue the search in the next word
            cur_word_nxt = cur_word_r + WADDR_W'(1);
            first_nxt    = 1'b0;
            rd_en        = 1'b1;
            rd_addr      = cur_word_r + WADDR_W'(1);
          end
        end

        ST_RECOUNT: begin
          acc_nxt = acc_r + CNT_W'(scan.ones);
          if (cur_word_r == WADDR_W'(WORD_COUNT - 1)) begin
            count_nxt = acc_nxt;
            state_nxt = ST_IDLE;
          end else begin
            cur_word_nxt = cur_word_r + WADDR_W'(1);
            rd_en        = 1'b1;
            rd_addr      = cur_word_r + WADDR_W'(1);
          end
        end

        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= CNT_W'(MAX_VARIABLES);
      count_r     <= '0;
      acc_r       <= '0;
      cur_word_r  <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      wvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      count_r     <= count_nxt;
      acc_r       <= acc_nxt;
      cur_word_r  <= cur_word_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      wvalid_r    <= wvalid_nxt;
    end
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    oor_r <= oor_nxt;
    bit_r <= bit_nxt;
    out_r <= out_nxt;
  end

  // mark RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_word_r] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // RAM is only written when a mark or unmark transaction completes
  a_write_only_on_mark: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_WORK) && !oor_r && (is_mark || is_unmark) && can_emit)
    else $error("bitmap write outside a mark transaction");

  // filled count never exceeds the variable count once settled
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (count_r <= n_eff))
    else $error("filled count above variable count");

  // a found index lies below the count and never on an out-of-range target
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |->
      (CNT_W'(out_r.found_index) < n_eff) && !out_r.out_of_range)
    else $error("found index out of range");

  // a finished result is not dropped while the receiver stalls
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_r))
    else $error("stalled result lost");

  // no transaction is taken during a recount pass
  a_no_accept_in_recount: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RECOUNT) |-> in_stall)
    else $error("input accepted during recount");

endmodule
`default_nettype wire

### design/bfns_scan.sv
`default_nettype none
module bfns_scan (
  input  wire logic [bfns_pkg::WORD_BITS-1:0] word,
  input  wire logic [bfns_pkg::WADDR_W-1:0]   word_idx,
  input  wire logic [bfns_pkg::BIT_W-1:0]     lo_bit,
  input  wire logic                           first,
  input  wire logic [bfns_pkg::CNT_W-1:0]     n_eff,
  input  wire logic                           want,
  output bfns_pkg::scan_res_t                 res
);
  import bfns_pkg::*;

  localparam int CHUNKS = (WORD_BITS + 7) / 8;
  localparam int HI_W   = CNT_W - BIT_W;

  logic [WORD_BITS-1:0] upper_mask;
  logic [WORD_BITS-1:0] lower_mask;
  logic [WORD_BITS-1:0] in_range;
  logic [WORD_BITS-1:0] match;
  logic [HI_W-1:0]      n_hi;
  logic [HI_W-1:0]      w_hi;
  logic [3:0]           chunk_ones [CHUNKS];

  assign n_hi = n_eff[CNT_W-1:BIT_W];
  assign w_hi = HI_W'(word_idx);

  // bits of this word that lie below the variable count
  always_comb begin
    if (n_hi > w_hi) begin
      upper_mask = '1;
    end else if (n_hi == w_hi) begin
      upper_mask = (WORD_BITS'(1) << n_eff[BIT_W-1:0]) - WORD_BITS'(1);
    end else begin
      upper_mask = '0;
    end
  end

  assign lower_mask = first ? ~((WORD_BITS'(1) << lo_bit) - WORD_BITS'(1)) : '1;
  assign in_range   = word & upper_mask;
  assign match      = (want ? word : ~word) & upper_mask & lower_mask;

  // popcount: per-byte counts, then byte sum
  always_comb begin
    for (int c = 0; c < CHUNKS; c++) begin
      chunk_ones[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (c * 8 + b < WORD_BITS) begin
          chunk_ones[c] = chunk_ones[c] + 4'(in_range[c * 8 + b]);
        end
      end
    end
  end

  // byte sum, and lowest set bit of the match vector
  always_comb begin
    res.ones = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      res.ones = res.ones + POP_W'(chunk_ones[c]);
    end
    res.hit = |match;
    res.pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (match[i]) begin
        res.pos = BIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire
